/* rtl/core/djd_pkg.sv */
// Package for the job dispatcher core: payload widths, result kinds,
// table entry layout and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package djd_pkg;

  localparam int ID_W        = 16;
  localparam int TASK_W      = 16;
  localparam int WORKER_W    = 3;
  localparam int WC_W        = 4;
  localparam int MAX_WORKERS = 8;

  localparam logic [1:0] KIND_ACK      = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_REJECT   = 2'd2;
  localparam logic [1:0] KIND_BAD_DONE = 2'd3;

  localparam logic CMD_SCHEDULE = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TASK_W-1:0] task_h;
    logic              dv;
    logic [ID_W-1:0]   dep;
  } pend_entry_t;

  typedef enum logic [1:0] {
    RA_I    = 2'd0,
    RA_K    = 2'd1,
    RA_LAST = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic       load_item;
    logic       sched_write;
    logic       done_push;
    logic       lat_cand;
    logic       clr_i;
    logic       inc_i;
    logic       clr_k;
    logic       inc_k;
    logic       wr_swap;
    logic       push;
    logic [1:0] push_kind;
    logic       flush;
    rd_sel_t    ra_sel;
  } djd_cmd_t;

  typedef struct packed {
    logic is_done;
    logic full;
    logic bad_done;
    logic can_disp;
    logic cand_free;
    logic id_hit;
    logic i_last;
    logic k_last;
    logic slot_free;
    logic hold_valid;
  } djd_sts_t;

endpackage
`default_nettype wire

/* rtl/core/djd_in_if.sv */
// Input channel of the job dispatcher: valid/ready plus one input word.
// Depends on djd_pkg.
`default_nettype none
interface djd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [djd_pkg::TASK_W-1:0] task_handle;
  logic                      dep_valid;
  logic [djd_pkg::ID_W-1:0]  dep_id;
  logic [djd_pkg::WORKER_W-1:0] worker_index;

  modport source(output valid, command, task_handle, dep_valid, dep_id, worker_index,
                 input ready);
  modport sink(input valid, command, task_handle, dep_valid, dep_id, worker_index,
               output ready);
endinterface
`default_nettype wire

/* rtl/core/djd_out_if.sv */
// Result channel of the job dispatcher: valid/ready plus one result word.
// Depends on djd_pkg.
`default_nettype none
interface djd_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [djd_pkg::ID_W-1:0]     job_id;
  logic [djd_pkg::TASK_W-1:0]   task_out;
  logic [djd_pkg::WORKER_W-1:0] worker_out;
  logic                         last;

  modport source(output valid, kind, job_id, task_out, worker_out, last, input ready);
  modport sink(input valid, kind, job_id, task_out, worker_out, last, output ready);
endinterface
`default_nettype wire

/* rtl/core/djd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module djd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/djd_ctrl.sv */
// Controller state machine of the job dispatcher: sequences one word at a time.
// Depends on djd_pkg.
`default_nettype none
module djd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire djd_pkg::djd_sts_t sts,
  output djd_pkg::djd_cmd_t      cmd
);
  import djd_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_EXEC  = 11'b000_0000_0010,
    S_RD_I  = 11'b000_0000_0100,
    S_CHK_I = 11'b000_0000_1000,
    S_RD_K  = 11'b000_0001_0000,
    S_CHK_K = 11'b000_0010_0000,
    S_DISP  = 11'b000_0100_0000,
    S_RD_L  = 11'b000_1000_0000,
    S_WR_L  = 11'b001_0000_0000,
    S_LOOP  = 11'b010_0000_0000,
    S_FLUSH = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.ra_sel = RA_I;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_done && !sts.bad_done) begin
          cmd.done_push = 1'b1;
          state_next = S_LOOP;
        end else if (sts.slot_free) begin
          cmd.push = 1'b1;
          state_next = S_LOOP;
          if (sts.is_done) begin
            cmd.push_kind = KIND_BAD_DONE;
          end else if (sts.full) begin
            cmd.push_kind = KIND_REJECT;
          end else begin
            cmd.push_kind = KIND_ACK;
            cmd.sched_write = 1'b1;
          end
        end
      end
      S_LOOP: begin
        if (sts.can_disp) begin
          cmd.clr_i = 1'b1;
          state_next = S_RD_I;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_RD_I: begin
        cmd.ra_sel = RA_I;
        state_next = S_CHK_I;
      end
      S_CHK_I: begin
        cmd.lat_cand = 1'b1;
        if (sts.cand_free) begin
          state_next = S_DISP;
        end else begin
          cmd.clr_k = 1'b1;
          state_next = S_RD_K;
        end
      end
      S_RD_K: begin
        cmd.ra_sel = RA_K;
        state_next = S_CHK_K;
      end
      S_CHK_K: begin
        if (sts.id_hit) begin
          if (sts.i_last) begin
            state_next = S_FLUSH;
          end else begin
            cmd.inc_i = 1'b1;
            state_next = S_RD_I;
          end
        end else if (sts.k_last) begin
          state_next = S_DISP;
        end else begin
          cmd.inc_k = 1'b1;
          state_next = S_RD_K;
        end
      end
      S_DISP: begin
        if (sts.slot_free) begin
          cmd.push = 1'b1;
          cmd.push_kind = KIND_DISPATCH;
          state_next = S_RD_L;
        end
      end
      S_RD_L: begin
        cmd.ra_sel = RA_LAST;
        state_next = S_WR_L;
      end
      S_WR_L: begin
        cmd.wr_swap = 1'b1;
        state_next = S_LOOP;
      end
      S_FLUSH: begin
        if (!sts.hold_valid || sts.slot_free) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

/* rtl/core/djd_dp.sv */
// Datapath of the job dispatcher: pending table RAM, free worker stack,
// counters, scan indexes and the held/output result registers.
// Depends on djd_pkg and djd_ram.
`default_nettype none
module djd_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire djd_pkg::djd_cmd_t          cmd,
  output djd_pkg::djd_sts_t               sts,
  input  wire logic                       cfg_we,
  input  wire logic [djd_pkg::WC_W-1:0]   cfg_data,
  input  wire logic                       in_command,
  input  wire logic [djd_pkg::TASK_W-1:0] in_task,
  input  wire logic                       in_dv,
  input  wire logic [djd_pkg::ID_W-1:0]   in_dep,
  input  wire logic [djd_pkg::WORKER_W-1:0] in_worker,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_kind,
  output logic [djd_pkg::ID_W-1:0]        out_job_id,
  output logic [djd_pkg::TASK_W-1:0]      out_task,
  output logic [djd_pkg::WORKER_W-1:0]    out_worker,
  output logic                            out_last
);
  import djd_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(pend_entry_t);

  typedef struct packed {
    logic [1:0]          kind;
    logic [ID_W-1:0]     id;
    logic [TASK_W-1:0]   task_h;
    logic [WORKER_W-1:0] worker;
  } res_t;

  // Item latched at acceptance.
  logic                cmd_q;
  logic [TASK_W-1:0]   task_q;
  logic                dv_q;
  logic [ID_W-1:0]     dep_q;
  logic [WORKER_W-1:0] w_q;

  logic [CW-1:0]       cnt;
  logic [ID_W-1:0]     next_id;
  logic [WC_W-1:0]     wc;
  logic [WORKER_W-1:0] stk [MAX_WORKERS];
  logic [WC_W-1:0]     fcnt;
  logic [IW-1:0]       i_idx;
  logic [IW-1:0]       k_idx;
  pend_entry_t         cand;
  res_t                hold;
  logic                hold_valid;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [IW-1:0]       ram_raddr;
  pend_entry_t         ram_wdata;
  logic [EW-1:0]       ram_rdata;
  pend_entry_t         rd_ent;
  logic                in_stack;
  logic [WORKER_W-1:0] top_worker;
  res_t                new_res;
  logic                slot_free;
  logic [WC_W-1:0]     cfg_clamped;

  assign rd_ent = pend_entry_t'(ram_rdata);
  assign top_worker = stk[WORKER_W'(fcnt - 1'b1)];
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = WC_W'(1);
    end else if (cfg_data > WC_W'(MAX_WORKERS)) begin
      cfg_clamped = WC_W'(MAX_WORKERS);
    end
  end

  always_comb begin
    in_stack = 1'b0;
    for (int j = 0; j < MAX_WORKERS; j++) begin
      if ((WC_W'(j) < fcnt) && (stk[j] == w_q)) begin
        in_stack = 1'b1;
      end
    end
  end

  always_comb begin
    sts.is_done    = (cmd_q != CMD_SCHEDULE);
    sts.full       = (cnt >= CW'(QUEUE_DEPTH));
    sts.bad_done   = ({1'b0, w_q} >= wc) || in_stack || (fcnt >= WC_W'(MAX_WORKERS));
    sts.can_disp   = (fcnt != '0) && (cnt != '0);
    sts.cand_free  = !rd_ent.dv;
    sts.id_hit     = (rd_ent.id == cand.dep);
    sts.i_last     = ((CW'(i_idx) + 1'b1) == cnt);
    sts.k_last     = ((CW'(k_idx) + 1'b1) == cnt);
    sts.slot_free  = slot_free;
    sts.hold_valid = hold_valid;
  end

  always_comb begin
    unique case (cmd.ra_sel)
      RA_I:    ram_raddr = i_idx;
      RA_K:    ram_raddr = k_idx;
      RA_LAST: ram_raddr = IW'(cnt - 1'b1);
      default: ram_raddr = i_idx;
    endcase
  end

  always_comb begin
    ram_we = cmd.sched_write || cmd.wr_swap;
    if (cmd.wr_swap) begin
      ram_waddr = i_idx;
      ram_wdata = rd_ent;
    end else begin
      ram_waddr = IW'(cnt);
      ram_wdata = '{id: next_id, task_h: task_q, dv: dv_q, dep: dep_q};
    end
  end

  always_comb begin
    new_res = '0;
    new_res.kind = cmd.push_kind;
    case (cmd.push_kind)
      KIND_ACK: begin
        new_res.id = next_id;
      end
      KIND_DISPATCH: begin
        new_res.id = cand.id;
        new_res.task_h = cand.task_h;
        new_res.worker = top_worker;
      end
      default: begin
        new_res.id = '0;
      end
    endcase
  end

  djd_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_q  <= in_command;
      task_q <= in_task;
      dv_q   <= in_dv;
      dep_q  <= in_dep;
      w_q    <= in_worker;
    end
    if (cmd.lat_cand) begin
      cand <= rd_ent;
    end
    if (cmd.clr_i) begin
      i_idx <= '0;
    end else if (cmd.inc_i) begin
      i_idx <= i_idx + 1'b1;
    end
    if (cmd.clr_k) begin
      k_idx <= '0;
    end else if (cmd.inc_k) begin
      k_idx <= k_idx + 1'b1;
    end
    if (cmd.push) begin
      hold <= new_res;
    end
    if (cmd.push && hold_valid) begin
      out_kind   <= hold.kind;
      out_job_id <= hold.id;
      out_task   <= hold.task_h;
      out_worker <= hold.worker;
      out_last   <= 1'b0;
    end else if (cmd.flush && hold_valid) begin
      out_kind   <= hold.kind;
      out_job_id <= hold.id;
      out_task   <= hold.task_h;
      out_worker <= hold.worker;
      out_last   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      next_id    <= '0;
      wc         <= WC_W'(MAX_WORKERS);
      fcnt       <= WC_W'(MAX_WORKERS);
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int j = 0; j < MAX_WORKERS; j++) begin
        stk[j] <= WORKER_W'(j);
      end
    end else begin
      if (cfg_we) begin
        wc   <= cfg_clamped;
        fcnt <= cfg_clamped;
        for (int j = 0; j < MAX_WORKERS; j++) begin
          stk[j] <= WORKER_W'(j);
        end
      end else if (cmd.done_push) begin
        stk[WORKER_W'(fcnt)] <= w_q;
        fcnt <= fcnt + 1'b1;
      end else if (cmd.wr_swap) begin
        fcnt <= fcnt - 1'b1;
      end
      if (cmd.sched_write) begin
        cnt     <= cnt + 1'b1;
        next_id <= next_id + 1'b1;
      end else if (cmd.wr_swap) begin
        cnt <= cnt - 1'b1;
      end
      if (cmd.push) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if ((cmd.push || cmd.flush) && hold_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result may only move into the output register when that register is free.
  a_push_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.push || cmd.flush) && hold_valid |-> slot_free)
    else $error("result moved into a busy output register");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QUEUE_DEPTH))
    else $error("pending count above table depth");

  a_fcnt_range: assert property (@(posedge clk) disable iff (rst)
    fcnt <= wc)
    else $error("free count above worker count");

  // A dispatch removes a job only while both a job and a worker exist.
  a_swap_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_swap |-> (cnt != '0) && (fcnt != '0))
    else $error("removal with empty table or stack");
endmodule
`default_nettype wire

/* rtl/core/dependency_aware_job_dispatcher_core.sv */
// Top level of the dependency-aware job dispatcher core.
// Depends on djd_pkg, djd_in_if, djd_out_if, djd_ram, djd_ctrl and djd_dp.
//
// Usage: in_ch carries one input word per handshake. A schedule word
// (command 0) adds a job with the next id and answers with an ack, or a
// reject when the pending table holds QUEUE_DEPTH jobs. A done word
// (command 1) returns a worker to the free stack, or answers bad done
// for an unknown or already free worker. After every word the core
// dispatches pending jobs whose dependency is no longer in the table,
// one dispatch result per job, until no worker is free or no job is ready.
// out_ch delivers results in order; last marks the final result of a word.
// The core handles one word at a time: accept, execute, final loop
// check and flush, plus, per dispatch pass, a read and a check of each
// candidate entry from the table RAM, a read and a compare of each entry
// scanned for the candidate's dependency, and the loop check and the
// removal. The scan loop reads the table RAM one entry at a time.
// Reset empties the table, zeroes the id counter and makes all eight
// workers free. Writing cfg_data sets the worker count (clamped to 1..8)
// and refills the free stack. When the receiver stalls, the core holds
// its output register and waits; it accepts a new word once the previous
// word's results are all in the output register.
`default_nettype none
module dependency_aware_job_dispatcher_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  djd_in_if.sink                        in_ch,
  djd_out_if.source                     out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [djd_pkg::WC_W-1:0] cfg_data
);
  import djd_pkg::*;

  djd_cmd_t cmd;
  djd_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  // Controller: sequences acceptance, table scan, removal and result flush.
  djd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Datapath: table, worker stack, counters and result registers.
  djd_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_command(in_ch.command),
    .in_task   (in_ch.task_handle),
    .in_dv     (in_ch.dep_valid),
    .in_dep    (in_ch.dep_id),
    .in_worker (in_ch.worker_index),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_job_id(out_ch.job_id),
    .out_task  (out_ch.task_out),
    .out_worker(out_ch.worker_out),
    .out_last  (out_ch.last)
  );
endmodule
`default_nettype wire

/* sim/dependency_aware_job_dispatcher_core_tb.sv */
// Self-checking testbench for dependency_aware_job_dispatcher_core.
// Depends on djd_pkg, djd_in_if, djd_out_if and the core RTL. A built-in predictor
// of the job table and free-worker stack checks every result word in order.
`default_nettype none
module dependency_aware_job_dispatcher_core_tb;
  import djd_pkg::*;

  localparam int TABLE_DEPTH = 16;
  // Quiet period after a config write or at the end. It covers the slowest word:
  // up to nine dispatch passes, each scanning a full table.
  localparam int SETTLE_CYCLES = 6000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic              cmd;
    logic [TASK_W-1:0] th;
    logic              dv;
    logic [ID_W-1:0]   dep;
    logic [WORKER_W-1:0] w;
  } job_word_t;

  typedef struct {
    logic [1:0]          kind;
    logic [ID_W-1:0]     id;
    logic [TASK_W-1:0]   th;
    logic [WORKER_W-1:0] w;
    logic                last;
  } result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [WC_W-1:0] cfg_data;

  djd_in_if  in_ch();
  djd_out_if out_ch();

  dependency_aware_job_dispatcher_core #(.QUEUE_DEPTH(TABLE_DEPTH)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Model of the core's state. The table arrays keep the same swap-with-last
  // order as the hardware, since dispatch order depends on table position.
  logic [ID_W-1:0]     tbl_id [TABLE_DEPTH];
  logic [TASK_W-1:0]   tbl_task [TABLE_DEPTH];
  logic                tbl_dv [TABLE_DEPTH];
  logic [ID_W-1:0]     tbl_dep [TABLE_DEPTH];
  int                  tbl_count;
  logic [WORKER_W-1:0] free_stk [MAX_WORKERS];
  int                  free_count;
  int                  workers_used;
  logic [ID_W-1:0]     next_id;

  job_word_t word_q[$];
  result_t   result_q[$];
  int  fails;
  int  cycle_cnt;
  int  accepted_results;
  int  hold_left;
  bit  hold_done;

  function automatic bit quiet_window();
    return cycle_cnt >= 3000 && cycle_cnt < 6000;
  endfunction

  function automatic result_t mk_result(logic [1:0] k, logic [ID_W-1:0] id,
                                        logic [TASK_W-1:0] th, logic [WORKER_W-1:0] w);
    result_t r;
    r.kind = k;
    r.id = id;
    r.th = th;
    r.w = w;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void add_result(result_t r);
    result_q.insert(result_q.size(), r);
  endfunction

  task automatic set_worker_count(logic [WC_W-1:0] v);
    workers_used = (v < 1) ? 1 : (v > MAX_WORKERS) ? MAX_WORKERS : int'(v);
    for (int i = 0; i < MAX_WORKERS; i++) free_stk[i] = WORKER_W'(i);
    free_count = workers_used;
  endtask

  function automatic bit id_in_table(logic [ID_W-1:0] id);
    for (int j = 0; j < tbl_count; j++) if (tbl_id[j] == id) return 1'b1;
    return 1'b0;
  endfunction

  // Works out the result words of one accepted input word and queues them.
  task automatic predict_word(job_word_t wd);
    int  first;
    int  sel;
    int  lst;
    bit  bad;
    bit  found;
    first = result_q.size();
    if (wd.cmd == CMD_SCHEDULE) begin
      if (tbl_count >= TABLE_DEPTH) begin
        add_result(mk_result(KIND_REJECT, '0, '0, '0));
      end else begin
        tbl_id[tbl_count] = next_id;
        tbl_task[tbl_count] = wd.th;
        tbl_dv[tbl_count] = wd.dv;
        tbl_dep[tbl_count] = wd.dep;
        tbl_count++;
        add_result(mk_result(KIND_ACK, next_id, '0, '0));
        next_id = next_id + 1'b1;
      end
    end else begin
      bad = (int'(wd.w) >= workers_used);
      for (int i = 0; i < free_count; i++) if (free_stk[i] == wd.w) bad = 1'b1;
      if (bad || free_count >= MAX_WORKERS) begin
        add_result(mk_result(KIND_BAD_DONE, '0, '0, '0));
      end else begin
        free_stk[free_count] = wd.w;
        free_count++;
      end
    end
    // Dispatch loop: first entry whose dependency has left the table.
    while (free_count > 0 && tbl_count > 0) begin
      found = 1'b0;
      sel = 0;
      for (int i = 0; i < tbl_count && !found; i++) begin
        if (!tbl_dv[i] || !id_in_table(tbl_dep[i])) begin
          sel = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      free_count--;
      add_result(mk_result(KIND_DISPATCH, tbl_id[sel], tbl_task[sel],
                           free_stk[free_count]));
      lst = tbl_count - 1;
      tbl_id[sel] = tbl_id[lst];
      tbl_task[sel] = tbl_task[lst];
      tbl_dv[sel] = tbl_dv[lst];
      tbl_dep[sel] = tbl_dep[lst];
      tbl_count = lst;
    end
    if (result_q.size() > first) result_q[result_q.size() - 1].last = 1'b1;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) cycle_cnt <= 0;
    else cycle_cnt <= cycle_cnt + 1;
  end

  // Driver: predicts each word as it is accepted, then offers the next one.
  always @(posedge clk) begin
    job_word_t nxt;
    bit offer;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        nxt.cmd = in_ch.command;
        nxt.th = in_ch.task_handle;
        nxt.dv = in_ch.dep_valid;
        nxt.dep = in_ch.dep_id;
        nxt.w = in_ch.worker_index;
        predict_word(nxt);
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer = word_q.size() > 0 && (quiet_window() || $urandom_range(99) >= 26);
        if (offer) begin
          nxt = word_q.pop_front();
          in_ch.command <= nxt.cmd;
          in_ch.task_handle <= nxt.th;
          in_ch.dep_valid <= nxt.dv;
          in_ch.dep_id <= nxt.dep;
          in_ch.worker_index <= nxt.w;
        end
        in_ch.valid <= offer;
      end
    end
  end

  // Long receiver stall: after the first few dozen results the receiver
  // holds off for a fixed stretch so the core fills its output and stalls
  // the input side.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_results >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Monitor: compares every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      accepted_results <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        accepted_results <= accepted_results + 1;
        if (result_q.size() == 0) begin
          $error("unexpected result word kind=%0d job_id=%0d", out_ch.kind, out_ch.job_id);
          fails++;
        end else begin
          e = result_q.pop_front();
          if (out_ch.kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_ch.kind);
            fails++;
          end
          if (out_ch.job_id !== e.id) begin
            $error("job_id: expected %0d, got %0d", e.id, out_ch.job_id);
            fails++;
          end
          if (out_ch.task_out !== e.th) begin
            $error("task_out: expected %0d, got %0d", e.th, out_ch.task_out);
            fails++;
          end
          if (out_ch.worker_out !== e.w) begin
            $error("worker_out: expected %0d, got %0d", e.w, out_ch.worker_out);
            fails++;
          end
          if (out_ch.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_ch.last);
            fails++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet_window() || $urandom_range(99) >= 26;
      end
    end
  end

  task automatic send(logic cmd, logic [TASK_W-1:0] th, logic dv,
                      logic [ID_W-1:0] dep, logic [WORKER_W-1:0] w);
    job_word_t wd;
    wd.cmd = cmd;
    wd.th = th;
    wd.dv = dv;
    wd.dep = dep;
    wd.w = w;
    word_q.insert(word_q.size(), wd);
    // Keep the generator close to the predictor so it can aim at busy workers.
    while (word_q.size() > 1) @(posedge clk);
  endtask

  task automatic drain();
    while (word_q.size() > 0 || in_ch.valid || result_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_worker_count(logic [WC_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    set_worker_count(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random word: mostly schedules with recent dependencies (mostly done words once
  // ten jobs are pending); done words usually name a busy worker, bad ones mixed in.
  task automatic send_random();
    logic [WORKER_W-1:0] w;
    logic [ID_W-1:0] dep;
    bit on_stack;
    int pick;
    pick = $urandom_range(99);
    if ((tbl_count >= 10 && pick < 70) || pick < 40) begin
      w = WORKER_W'($urandom_range(7));
      for (int t = 0; t < 8 && $urandom_range(9) < 8; t++) begin
        on_stack = (int'(w) >= workers_used);
        for (int i = 0; i < free_count; i++) if (free_stk[i] == w) on_stack = 1'b1;
        if (!on_stack) break;
        w = WORKER_W'($urandom_range(7));
      end
      send(1'b1, TASK_W'($urandom), 1'($urandom), ID_W'($urandom), w);
    end else begin
      if ($urandom_range(9) < 7) dep = next_id - ID_W'($urandom_range(4, 1));
      else dep = ID_W'($urandom);
      send(1'b0, TASK_W'($urandom), 1'($urandom_range(9) < 6), dep, 3'($urandom));
    end
  endtask

  initial begin
    fails = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.task_handle = '0;
    in_ch.dep_valid = 1'b0;
    in_ch.dep_id = '0;
    in_ch.worker_index = '0;
    out_ch.ready = 1'b0;
    tbl_count = 0;
    next_id = '0;
    set_worker_count(4'd8);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Eight workers after reset: field extremes, a met dependency, a double done.
    send(1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 3'd7);
    send(1'b0, 16'h0000, 1'b0, 16'h0000, 3'd0);
    send(1'b0, 16'h1234, 1'b1, 16'd1, 3'd0);
    send(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 3'd7);
    send(1'b1, 16'h0000, 1'b0, 16'h0000, 3'd7);
    send(1'b1, 16'h0000, 1'b0, 16'h0000, 3'd6);
    send(1'b1, 16'h0000, 1'b0, 16'h0000, 3'd0);
    repeat (130) send_random();

    // A count of zero clamps to one worker; fill the table until a reject.
    write_worker_count(4'd0);
    for (int i = 0; i < 18; i++) send(1'b0, TASK_W'(16'hA000 + i), 1'b0, '0, '0);
    send(1'b1, 16'h0, 1'b0, 16'h0, 3'd1);
    send(1'b1, 16'h0, 1'b0, 16'h0, 3'd0);
    repeat (40) send_random();

    // Out-of-range count clamps to eight workers.
    write_worker_count(4'd15);
    repeat (80) send_random();

    write_worker_count(4'd5);
    repeat (70) send_random();

    // A job that depends on its own id stays in the table for good.
    write_worker_count(4'd1);
    send(1'b0, 16'h5A5A, 1'b1, next_id, 3'd0);
    repeat (20) send_random();

    drain();
    if (fails == 0) begin
      $display("PASS dependency_aware_job_dispatcher_core");
    end else begin
      $display("FAIL dependency_aware_job_dispatcher_core");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAIL dependency_aware_job_dispatcher_core");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/djd_pkg.sv
rtl/core/djd_in_if.sv
rtl/core/djd_out_if.sv
rtl/core/djd_ram.sv
rtl/core/djd_ctrl.sv
rtl/core/djd_dp.sv
rtl/core/dependency_aware_job_dispatcher_core.sv
sim/dependency_aware_job_dispatcher_core_tb.sv
